>>> rtl/urrs_pkg.sv
// Shared types and constants for the undo/redo ring stack unit.
package urrs_pkg;

  localparam int HISTORY_DEPTH = 128;
  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_UNDO = 2'd1;
  localparam logic [1:0] CMD_REDO = 2'd2;

  // one edit record as held in either stack memory
  typedef struct packed {
    logic        kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [3:0]  layer;
    logic [15:0] oldv;
    logic [15:0] newv;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // pointer update request for one ring
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_op_t;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

>>> rtl/urrs_if.sv
// Valid/ready channel interfaces for edit commands and tile write results.
interface urrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        clear_redo;
  logic        edit_kind;
  logic [11:0] tile_x;
  logic [11:0] tile_y;
  logic [3:0]  tile_layer;
  logic [15:0] old_value;
  logic [15:0] new_value;

  modport source (
    output valid, cmd, clear_redo, edit_kind, tile_x, tile_y, tile_layer,
           old_value, new_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, clear_redo, edit_kind, tile_x, tile_y, tile_layer,
           old_value, new_value,
    output ready
  );
endinterface

interface urrs_out_if;
  logic        valid;
  logic        ready;
  logic        write_en;
  logic [11:0] out_x;
  logic [11:0] out_y;
  logic [3:0]  out_layer;
  logic [15:0] out_value;
  logic [7:0]  undo_depth;
  logic [7:0]  redo_depth;

  modport source (
    output valid, write_en, out_x, out_y, out_layer, out_value, undo_depth,
           redo_depth,
    input  ready
  );
  modport sink (
    input  valid, write_en, out_x, out_y, out_layer, out_value, undo_depth,
           redo_depth,
    output ready
  );
endinterface

>>> rtl/urrs_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module urrs_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 61
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/urrs_ring.sv
// Top pointer and saturating count of one ring stack.
module urrs_ring
  import urrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ring_op_t op,
  output ptr_t     top_r,
  output ptr_t     pop_addr,
  output cnt_t     count_r,
  output cnt_t     count_nxt
);

  localparam ptr_t LAST = PTR_W'(HISTORY_DEPTH - 1);
  localparam cnt_t FULL = CNT_W'(HISTORY_DEPTH);

  ptr_t top_nxt;

  // entry below the top, wrapping to the last slot
  assign pop_addr = (top_r == '0) ? LAST : top_r - 1'b1;

  // next pointer and count
  always_comb begin
    top_nxt   = top_r;
    count_nxt = count_r;
    if (op.clear) begin
      top_nxt   = '0;
      count_nxt = '0;
    end else if (op.push) begin
      top_nxt = (top_r == LAST) ? '0 : top_r + 1'b1;
      if (count_r != FULL) begin
        count_nxt = count_r + 1'b1;
      end
    end else if (op.pop) begin
      top_nxt   = pop_addr;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= '0;
      count_r <= '0;
    end else begin
      top_r   <= top_nxt;
      count_r <= count_nxt;
    end
  end

  // a pop is only issued on a non-empty ring
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    op.pop |-> count_r != '0)
    else $error("pop on empty ring");

  // count saturates at the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("ring count above depth");

endmodule

>>> rtl/undo_redo_ring_stacks_unit.sv
// Undo/redo history: two ring stacks in RAM, one command at a time.
// Push, pop of an empty stack and unused codes give a result the cycle after the beat.
// Undo/redo on a non-empty stack pass through ST_READ: read one stack RAM, then write the other.
// A new command waits in ST_IDLE until that read-then-write RAM sequence ends and the result can load.
// Reset: pointers, counts and handshake state clear at once; the RAMs are not cleared.
module undo_redo_ring_stacks_unit
  import urrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  urrs_in_if.sink    in_ch,
  urrs_out_if.source out_ch
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic       state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic       accept;
  rec_t       in_rec, rd_rec;

  ring_op_t undo_op, redo_op;
  ptr_t     undo_top, undo_pop_addr, redo_top, redo_pop_addr;
  cnt_t     undo_cnt, undo_cnt_nxt, redo_cnt, redo_cnt_nxt;

  logic             undo_we, undo_re, redo_we, redo_re;
  logic [REC_W-1:0] undo_wdata, redo_wdata, undo_rdata, redo_rdata;

  logic        load_out;
  logic        o_we;
  logic [11:0] o_x, o_y;
  logic [3:0]  o_layer;
  logic [15:0] o_value;

  logic        out_valid_r;
  logic        out_we_r;
  logic [11:0] out_x_r, out_y_r;
  logic [3:0]  out_layer_r;
  logic [15:0] out_value_r;
  logic [7:0]  undo_depth_r, redo_depth_r;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign in_rec = '{kind: in_ch.edit_kind, x: in_ch.tile_x, y: in_ch.tile_y,
                    layer: in_ch.tile_layer, oldv: in_ch.old_value,
                    newv: in_ch.new_value};
  assign rd_rec = (cmd_r == CMD_UNDO) ? rec_t'(undo_rdata) : rec_t'(redo_rdata);

  // stack pointers
  urrs_ring u_undo_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (undo_op),
    .top_r    (undo_top),
    .pop_addr (undo_pop_addr),
    .count_r  (undo_cnt),
    .count_nxt(undo_cnt_nxt)
  );

  urrs_ring u_redo_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (redo_op),
    .top_r    (redo_top),
    .pop_addr (redo_pop_addr),
    .count_r  (redo_cnt),
    .count_nxt(redo_cnt_nxt)
  );

  // record stores
  urrs_ram #(.DEPTH(HISTORY_DEPTH), .WIDTH(REC_W)) u_undo_ram (
    .clk    (clk),
    .we     (undo_we),
    .waddr  (undo_top),
    .wdata  (undo_wdata),
    .re     (undo_re),
    .raddr  (undo_pop_addr),
    .rdata_r(undo_rdata)
  );

  urrs_ram #(.DEPTH(HISTORY_DEPTH), .WIDTH(REC_W)) u_redo_ram (
    .clk    (clk),
    .we     (redo_we),
    .waddr  (redo_top),
    .wdata  (redo_wdata),
    .re     (redo_re),
    .raddr  (redo_pop_addr),
    .rdata_r(redo_rdata)
  );

  // command sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    undo_op    = '0;
    redo_op    = '0;
    undo_we    = 1'b0;
    undo_re    = 1'b0;
    redo_we    = 1'b0;
    redo_re    = 1'b0;
    undo_wdata = in_rec;
    redo_wdata = rd_rec;
    load_out   = 1'b0;
    o_we       = 1'b0;
    o_x        = '0;
    o_y        = '0;
    o_layer    = '0;
    o_value    = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.cmd)
            CMD_PUSH: begin
              undo_op.push  = 1'b1;
              undo_we       = 1'b1;
              redo_op.clear = in_ch.clear_redo;
              load_out      = 1'b1;
            end
            CMD_UNDO: begin
              if (undo_cnt != '0) begin
                undo_op.pop = 1'b1;
                undo_re     = 1'b1;
                cmd_nxt     = CMD_UNDO;
                state_nxt   = ST_READ;
              end else begin
                load_out = 1'b1;
              end
            end
            CMD_REDO: begin
              if (redo_cnt != '0) begin
                redo_op.pop = 1'b1;
                redo_re     = 1'b1;
                cmd_nxt     = CMD_REDO;
                state_nxt   = ST_READ;
              end else begin
                load_out = 1'b1;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        // popped record moves to the other stack, tile write goes out if its kind is set
        load_out  = 1'b1;
        state_nxt = ST_IDLE;
        if (cmd_r == CMD_UNDO) begin
          redo_op.push = 1'b1;
          redo_we      = 1'b1;
        end else begin
          undo_op.push = 1'b1;
          undo_we      = 1'b1;
          undo_wdata   = rd_rec;
        end
        if (rd_rec.kind) begin
          o_we    = 1'b1;
          o_x     = rd_rec.x;
          o_y     = rd_rec.y;
          o_layer = rd_rec.layer;
          o_value = (cmd_r == CMD_UNDO) ? rd_rec.oldv : rd_rec.newv;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_we_r     <= o_we;
      out_x_r      <= o_x;
      out_y_r      <= o_y;
      out_layer_r  <= o_layer;
      out_value_r  <= o_value;
      undo_depth_r <= 8'(undo_cnt_nxt);
      redo_depth_r <= 8'(redo_cnt_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.write_en   = out_we_r;
  assign out_ch.out_x      = out_x_r;
  assign out_ch.out_y      = out_y_r;
  assign out_ch.out_layer  = out_layer_r;
  assign out_ch.out_value  = out_value_r;
  assign out_ch.undo_depth = undo_depth_r;
  assign out_ch.redo_depth = redo_depth_r;

  // the read state always returns to idle in the cycle after
  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_IDLE)
    else $error("read state held");

  // no tile write means a zero tile address and value
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_we_r) |->
      (out_x_r == '0 && out_y_r == '0 && out_layer_r == '0 && out_value_r == '0))
    else $error("nonzero fields without write");

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the undo/redo ring stack unit: directed and random commands, scoreboarded results.
`timescale 1ns / 100ps

module tb_top;
  import urrs_pkg::*;

  // code the block treats as a no-op
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_CYCLES = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  // one command beat as driven on the input channel
  typedef struct packed {
    logic [1:0] op;
    logic       clear_redo;
    rec_t       rec;
  } edit_cmd_t;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic        write_en;
    logic [11:0] x;
    logic [11:0] y;
    logic [3:0]  layer;
    logic [15:0] value;
    logic [7:0]  undo_depth;
    logic [7:0]  redo_depth;
  } tile_write_t;

  logic clk = 1'b0;
  logic rst_n;

  urrs_in_if  in_ch ();
  urrs_out_if out_ch ();

  undo_redo_ring_stacks_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of both history rings
  rec_t undo_hist [HISTORY_DEPTH];
  rec_t redo_hist [HISTORY_DEPTH];
  ptr_t undo_top = '0;
  ptr_t redo_top = '0;
  cnt_t undo_cnt = '0;
  cnt_t redo_cnt = '0;

  tile_write_t pending_writes[$];

  int  beats_sent = 0;
  int  results_checked = 0;
  int  tile_writes = 0;
  int  mismatches = 0;
  int  cycles = 0;
  int  undo_peak = 0;
  int  redo_peak = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  steady = 1'b0;

  // apply one command to the shadow rings and return the result it should produce
  function automatic tile_write_t history_apply(input edit_cmd_t c);
    tile_write_t w;
    rec_t        r;
    w = '0;
    case (c.op)
      CMD_PUSH: begin
        undo_hist[undo_top] = c.rec;
        undo_top = undo_top + 1'b1;
        if (undo_cnt < HISTORY_DEPTH) undo_cnt = undo_cnt + 1'b1;
        if (c.clear_redo) begin
          redo_cnt = '0;
          redo_top = '0;
        end
      end
      CMD_UNDO: begin
        if (undo_cnt != 0) begin
          undo_cnt = undo_cnt - 1'b1;
          undo_top = undo_top - 1'b1;   // wrap before the read
          r = undo_hist[undo_top];
          if (r.kind) begin
            w.write_en = 1'b1;
            w.x = r.x;
            w.y = r.y;
            w.layer = r.layer;
            w.value = r.oldv;
          end
          redo_hist[redo_top] = r;
          redo_top = redo_top + 1'b1;
          if (redo_cnt < HISTORY_DEPTH) redo_cnt = redo_cnt + 1'b1;
        end
      end
      CMD_REDO: begin
        if (redo_cnt != 0) begin
          redo_cnt = redo_cnt - 1'b1;
          redo_top = redo_top - 1'b1;
          r = redo_hist[redo_top];
          if (r.kind) begin
            w.write_en = 1'b1;
            w.x = r.x;
            w.y = r.y;
            w.layer = r.layer;
            w.value = r.newv;
          end
          // redo leaves the redo ring otherwise alone
          undo_hist[undo_top] = r;
          undo_top = undo_top + 1'b1;
          if (undo_cnt < HISTORY_DEPTH) undo_cnt = undo_cnt + 1'b1;
        end
      end
      default: ;
    endcase
    w.undo_depth = undo_cnt;
    w.redo_depth = redo_cnt;
    if (undo_cnt > undo_peak) undo_peak = undo_cnt;
    if (redo_cnt > redo_peak) redo_peak = redo_cnt;
    if (w.write_en) tile_writes++;
    return w;
  endfunction

  // command with random content in every field, ignored ones included
  function automatic edit_cmd_t random_cmd(input logic [1:0] op);
    edit_cmd_t   c;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    c.op = op;
    c.clear_redo = ($urandom_range(9) == 0);
    c.rec = raw[REC_W-1:0];
    return c;
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CMD_PUSH;
    if (r < 65) return CMD_UNDO;
    if (r < 95) return CMD_REDO;
    return CMD_UNUSED;
  endfunction

  // drive one beat, wait for acceptance, log the expected result
  task automatic send_beat(input edit_cmd_t c);
    while (!steady && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c.op;
    in_ch.clear_redo <= c.clear_redo;
    in_ch.edit_kind  <= c.rec.kind;
    in_ch.tile_x     <= c.rec.x;
    in_ch.tile_y     <= c.rec.y;
    in_ch.tile_layer <= c.rec.layer;
    in_ch.old_value  <= c.rec.oldv;
    in_ch.new_value  <= c.rec.newv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_writes.push_back(history_apply(c));
    beats_sent++;
  endtask

  task automatic send_op(input logic [1:0] op);
    send_beat(random_cmd(op));
  endtask

  // sender goes quiet until every expected result is back
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // pops of empty rings and the unused code straight out of reset
  task automatic test_empty_and_unused();
    edit_cmd_t c;
    c = random_cmd(CMD_UNDO);
    c.clear_redo = 1'b1;
    send_beat(c);
    send_op(CMD_REDO);
    send_op(CMD_UNUSED);
    c = random_cmd(CMD_UNUSED);
    c.clear_redo = 1'b1;
    send_beat(c);
    wait_results_done();
  endtask

  // field extremes, each command, no-write kind and redo clearing
  task automatic test_directed_edits();
    edit_cmd_t c;
    c = random_cmd(CMD_PUSH);
    c.clear_redo = 1'b0;
    c.rec = '0;
    c.rec.kind = 1'b1;
    send_beat(c);
    c.rec = '1;
    c.clear_redo = 1'b1;
    send_beat(c);
    c = random_cmd(CMD_PUSH);
    c.rec.kind = 1'b0;
    send_beat(c);
    send_op(CMD_UNUSED);
    repeat (3) send_op(CMD_UNDO);   // no-write kind, all ones, all zeros
    send_op(CMD_UNDO);              // now empty
    repeat (2) send_op(CMD_REDO);
    c = random_cmd(CMD_PUSH);
    c.clear_redo = 1'b0;
    c.rec.kind = 1'b1;
    send_beat(c);
    repeat (2) send_op(CMD_REDO);   // last one finds the ring empty
    send_op(CMD_UNDO);
    c = random_cmd(CMD_PUSH);
    c.clear_redo = 1'b1;
    send_beat(c);
    send_op(CMD_REDO);              // redo ring was just cleared
    wait_results_done();
  endtask

  // overfill the undo ring, drain it into a full redo ring, then move part back
  task automatic test_history_wrap();
    edit_cmd_t c;
    steady = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH + 7; i++) begin
      if (i == 70) steady = 1'b0;
      send_op(CMD_PUSH);
    end
    repeat (HISTORY_DEPTH + 2) send_op(CMD_UNDO);
    repeat (40) send_op(CMD_REDO);
    repeat (2) begin
      c = random_cmd(CMD_PUSH);
      c.clear_redo = 1'b0;
      send_beat(c);
    end
    repeat (6) send_op(CMD_UNDO);
    wait_results_done();
  endtask

  // long output stall while commands keep coming
  task automatic test_output_stall();
    hold_req = 1'b1;
    repeat (40) send_op(pick_op());
    wait_results_done();
  endtask

  task automatic test_random_mix();
    repeat (100) send_op(pick_op());
    wait_results_done();
  endtask

  // result side: ready with random gaps and a requested long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // compare every result beat with the oldest expectation
  always @(posedge clk) begin
    tile_write_t exp_w;
    tile_write_t act_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      act_w.write_en   = out_ch.write_en;
      act_w.x          = out_ch.out_x;
      act_w.y          = out_ch.out_y;
      act_w.layer      = out_ch.out_layer;
      act_w.value      = out_ch.out_value;
      act_w.undo_depth = out_ch.undo_depth;
      act_w.redo_depth = out_ch.redo_depth;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result beat we=%0b x=%0d y=%0d", act_w.write_en,
                   act_w.x, act_w.y);
      end else begin
        exp_w = pending_writes.pop_front();
        results_checked++;
        if (act_w.write_en !== exp_w.write_en || act_w.x !== exp_w.x ||
            act_w.y !== exp_w.y || act_w.layer !== exp_w.layer ||
            act_w.value !== exp_w.value || act_w.undo_depth !== exp_w.undo_depth ||
            act_w.redo_depth !== exp_w.redo_depth) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: result %0d exp we=%0b x=%0d y=%0d l=%0d v=%h ud=%0d rd=%0d",
                     results_checked, exp_w.write_en, exp_w.x, exp_w.y, exp_w.layer,
                     exp_w.value, exp_w.undo_depth, exp_w.redo_depth);
            $display("       got               we=%0b x=%0d y=%0d l=%0d v=%h ud=%0d rd=%0d",
                     act_w.write_en, act_w.x, act_w.y, act_w.layer, act_w.value,
                     act_w.undo_depth, act_w.redo_depth);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_writes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_PUSH;
    in_ch.clear_redo <= 1'b0;
    in_ch.edit_kind  <= 1'b0;
    in_ch.tile_x     <= '0;
    in_ch.tile_y     <= '0;
    in_ch.tile_layer <= '0;
    in_ch.old_value  <= '0;
    in_ch.new_value  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_unused();
    test_directed_edits();
    test_history_wrap();
    test_output_stall();
    test_random_mix();

    $display("Sent %0d commands, checked %0d results, %0d tile writes, %0d mismatches",
             beats_sent, results_checked, tile_writes, mismatches);
    $display("Ring depth peaks: undo %0d, redo %0d (wraps and overwrites of oldest exercised)",
             undo_peak, redo_peak);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/urrs_pkg.sv
rtl/urrs_if.sv
rtl/urrs_ram.sv
rtl/urrs_ring.sv
rtl/undo_redo_ring_stacks_unit.sv
tb/sv/tb_top.sv
